FILE: sv/cc20_pkg.sv
// Shared types, constants and register codes for the ChaCha20 stream cipher core.
package cc20_pkg;

    // Round count default and word geometry
    localparam int ROUND_COUNT_DEF = 20;
    localparam int WORD_BITS       = 32;
    localparam int NUM_WORDS       = 16;
    localparam int STATE_BITS      = WORD_BITS * NUM_WORDS;
    localparam int PAD_BYTES       = STATE_BITS / 8;
    localparam int LEFT_BITS       = $clog2(PAD_BYTES + 1);

    // Constant words, 256-bit key form
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // 128-bit key form: word 1 drops, word 2 rises
    localparam logic [31:0] TAU_DELTA_1 = 32'h0200_0000;
    localparam logic [31:0] TAU_DELTA_2 = 32'h0000_0004;
    localparam logic [31:0] TAU_1       = SIGMA_1 - TAU_DELTA_1;
    localparam logic [31:0] TAU_2       = SIGMA_2 + TAU_DELTA_2;

    // Quarter-round rotate amounts, one per step
    localparam int ROT_0 = 16;
    localparam int ROT_1 = 12;
    localparam int ROT_2 = 8;
    localparam int ROT_3 = 7;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_256   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTR_START = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE     = 3'd6;

    // Block sequencer states
    typedef enum logic [2:0] {
        BLK_IDLE,
        BLK_SKEW,
        BLK_STEP,
        BLK_UNSKEW,
        BLK_ADD
    } t_blk_state;

    // Commands from the stream side to the block unit
    typedef struct packed {
        logic start;
        logic abort;
        logic consume;
    } t_blk_ctrl;

    // Status from the block unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_blk_stat;

endpackage

FILE: sv/cc20_block.sv
// ChaCha20 block unit: one shared add/xor/rotate step per cycle, plus the pad shift register.
module cc20_block import cc20_pkg::*; #(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_blk_ctrl             i_ctrl,
    input  logic [STATE_BITS-1:0] i_init,
    output t_blk_stat             o_stat,
    output logic [7:0]            o_ks_byte
);

    localparam int RW = $clog2(ROUND_COUNT + 1);

    t_blk_state            r_state, n_state;
    logic [RW-1:0]         r_round, n_round;
    logic [3:0]            r_step,  n_step;
    logic [31:0]           r_w [NUM_WORDS];
    logic [31:0]           n_w [NUM_WORDS];
    logic [31:0]           tmp_w [NUM_WORDS];
    logic [STATE_BITS-1:0] r_pad, n_pad;

    logic [1:0]    phase;
    logic [31:0]   op_x, op_y, op_z, sum, mix_in, mixed;
    logic [RW-1:0] round_inc;
    logic          round_end;
    logic          step_last;

    assign phase     = r_step[1:0];
    assign step_last = (r_step == 4'hF);
    assign round_inc = r_round + RW'(1);
    assign round_end = (round_inc == RW'(ROUND_COUNT));

    // Shared unit: one add, then xor and rotate; column 0 holds a, b, c, d
    always_comb begin
        if (r_state == BLK_ADD) begin
            op_x = r_w[0];
            op_y = i_init[r_step*WORD_BITS +: WORD_BITS];
            op_z = r_w[0];
        end else begin
            op_x = phase[0] ? r_w[8]  : r_w[0];
            op_y = phase[0] ? r_w[12] : r_w[4];
            op_z = phase[0] ? r_w[4]  : r_w[12];
        end
        sum    = op_x + op_y;
        mix_in = op_z ^ sum;
        unique case (phase)
            2'd0:    mixed = (mix_in << ROT_0) | (mix_in >> (WORD_BITS - ROT_0));
            2'd1:    mixed = (mix_in << ROT_1) | (mix_in >> (WORD_BITS - ROT_1));
            2'd2:    mixed = (mix_in << ROT_2) | (mix_in >> (WORD_BITS - ROT_2));
            default: mixed = (mix_in << ROT_3) | (mix_in >> (WORD_BITS - ROT_3));
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (i_ctrl.abort) begin
            n_state = BLK_IDLE;
        end else begin
            unique case (r_state)
                BLK_IDLE: begin
                    if (i_ctrl.start) n_state = BLK_STEP;
                end
                BLK_SKEW: begin
                    n_state = BLK_STEP;
                end
                BLK_STEP: begin
                    if (step_last) begin
                        if (r_round[0])     n_state = BLK_UNSKEW;
                        else if (round_end) n_state = BLK_ADD;
                        else                n_state = BLK_SKEW;
                    end
                end
                BLK_UNSKEW: begin
                    n_state = round_end ? BLK_ADD : BLK_STEP;
                end
                BLK_ADD: begin
                    if (step_last) n_state = BLK_IDLE;
                end
                default: n_state = BLK_IDLE;
            endcase
        end
    end

    // Datapath: working words, counters and pad
    always_comb begin
        n_round = r_round;
        n_step  = r_step;
        n_pad   = r_pad;
        tmp_w   = r_w;
        n_w     = r_w;
        if (i_ctrl.consume) n_pad = {8'h00, r_pad[STATE_BITS-1:8]};
        unique case (r_state)
            BLK_IDLE: begin
                if (i_ctrl.start) begin
                    for (int i = 0; i < NUM_WORDS; i++) n_w[i] = i_init[i*WORD_BITS +: WORD_BITS];
                    n_round = '0;
                    n_step  = '0;
                end
            end
            BLK_SKEW: begin
                // Rotate row k left by k words so diagonals line up as columns
                for (int k = 0; k < 4; k++)
                    for (int j = 0; j < 4; j++)
                        n_w[4*k + j] = r_w[4*k + ((j + k) & 3)];
            end
            BLK_STEP: begin
                if (!phase[0]) begin
                    tmp_w[0]  = sum;
                    tmp_w[12] = mixed;
                end else begin
                    tmp_w[8]  = sum;
                    tmp_w[4]  = mixed;
                end
                // After a full quarter round, bring the next column to slot 0
                if (phase == 2'd3) begin
                    for (int k = 0; k < 4; k++)
                        for (int j = 0; j < 4; j++)
                            n_w[4*k + j] = tmp_w[4*k + ((j + 1) & 3)];
                end else begin
                    n_w = tmp_w;
                end
                n_step = r_step + 4'd1;
                if (step_last && !r_round[0]) n_round = round_inc;
            end
            BLK_UNSKEW: begin
                for (int k = 0; k < 4; k++)
                    for (int j = 0; j < 4; j++)
                        n_w[4*k + j] = r_w[4*k + ((j + 4 - k) & 3)];
                n_round = round_inc;
            end
            BLK_ADD: begin
                // Shift words down; each sum enters the pad from the top
                for (int i = 0; i < NUM_WORDS - 1; i++) n_w[i] = r_w[i + 1];
                n_w[NUM_WORDS-1] = r_w[0];
                n_pad  = {sum, r_pad[STATE_BITS-1:WORD_BITS]};
                n_step = r_step + 4'd1;
            end
            default: begin
                n_step = '0;
            end
        endcase
    end

    // Status outputs
    always_comb begin
        o_stat.busy = (r_state != BLK_IDLE);
        o_stat.done = (r_state == BLK_ADD) && step_last && !i_ctrl.abort;
        o_ks_byte   = r_pad[7:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BLK_IDLE;
            r_round <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_step  <= n_step;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_pad <= n_pad;
    end

endmodule

FILE: sv/chacha20_stream_cipher_core.sv
// Top level of the ChaCha20 stream cipher core: configuration, byte stream and pad control.
//
// Each byte on the slave stream leaves on the master stream XORed with the next ChaCha20
// keystream byte; tlast passes through untouched. A 64-byte pad is built only when a byte
// arrives and no pad bytes remain: the shared add/xor/rotate unit runs the rounds one step
// at a time, with a skew step before and an unskew step after every diagonal round, then
// adds the input words into the pad; while a pad is built the slave side is not ready.
// Bytes that find pad bytes left pass at one per cycle through the output register while
// the master side takes them. Any write to a defined register (index 0 to 6) reloads the
// block counter from counter_start and discards the rest of the pad, also aborting a pad
// in progress; write registers only while the stream is idle.
module chacha20_stream_cipher_core import cc20_pkg::*; #(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] in_byte
    input  logic                  i_s_axis_tlast,
    // Master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [7:0] out_byte
    output logic                  o_m_axis_tlast
);

    logic [63:0]          r_key_0, r_key_1, r_key_2, r_key_3;
    logic                 r_key_256;
    logic [63:0]          r_ctr_start, r_nonce;
    logic [63:0]          r_ctr;
    logic [LEFT_BITS-1:0] r_left;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic                  cfg_hit;
    logic                  in_beat, out_beat;
    logic [STATE_BITS-1:0] init_words;
    t_blk_ctrl             blk_ctrl;
    t_blk_stat             blk_stat;
    logic [7:0]            ks_byte;

    assign cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_NONCE);

    // Accept a byte while pad bytes remain and the output slot frees up
    assign o_s_axis_tready = (r_left != '0) && !blk_stat.busy
                             && (!r_out_valid || i_m_axis_tready);
    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_beat = r_out_valid && i_m_axis_tready;

    // Build the sixteen input words of the block
    always_comb begin
        init_words[0*32 +: 32]  = SIGMA_0;
        init_words[1*32 +: 32]  = r_key_256 ? SIGMA_1 : TAU_1;
        init_words[2*32 +: 32]  = r_key_256 ? SIGMA_2 : TAU_2;
        init_words[3*32 +: 32]  = SIGMA_3;
        init_words[4*32 +: 64]  = r_key_0;
        init_words[6*32 +: 64]  = r_key_1;
        init_words[8*32 +: 64]  = r_key_256 ? r_key_2 : r_key_0;
        init_words[10*32 +: 64] = r_key_256 ? r_key_3 : r_key_1;
        init_words[12*32 +: 64] = r_ctr;
        init_words[14*32 +: 64] = r_nonce;
    end

    // Start a pad when a byte waits and none are left; a write to a defined register aborts
    always_comb begin
        blk_ctrl.abort   = cfg_hit;
        blk_ctrl.start   = i_s_axis_tvalid && (r_left == '0) && !blk_stat.busy && !i_cfg_we;
        blk_ctrl.consume = in_beat;
    end

    cc20_block #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_block (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (blk_ctrl),
        .i_init    (init_words),
        .o_stat    (blk_stat),
        .o_ks_byte (ks_byte)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_0     <= '0;
            r_key_1     <= '0;
            r_key_2     <= '0;
            r_key_3     <= '0;
            r_key_256   <= 1'b1;
            r_ctr_start <= '0;
            r_nonce     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_0:     r_key_0     <= i_cfg_data;
                CFG_KEY_1:     r_key_1     <= i_cfg_data;
                CFG_KEY_2:     r_key_2     <= i_cfg_data;
                CFG_KEY_3:     r_key_3     <= i_cfg_data;
                CFG_KEY_256:   r_key_256   <= i_cfg_data[0];
                CFG_CTR_START: r_ctr_start <= i_cfg_data;
                CFG_NONCE:     r_nonce     <= i_cfg_data;
                default:       r_nonce     <= r_nonce;
            endcase
        end
    end

    // Block counter and pad bytes left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr  <= '0;
            r_left <= '0;
        end else if (cfg_hit) begin
            r_ctr  <= (i_cfg_idx == CFG_CTR_START) ? i_cfg_data : r_ctr_start;
            r_left <= '0;
        end else if (blk_stat.done) begin
            r_ctr  <= r_ctr + 64'd1;
            r_left <= LEFT_BITS'(PAD_BYTES);
        end else if (in_beat) begin
            r_left <= r_left - LEFT_BITS'(1);
        end
    end

    // Output register: load on an input beat, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_byte <= i_s_axis_tdata ^ ks_byte;
            r_out_last <= i_s_axis_tlast;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

endmodule
